// ===== rtl/core/matrix3x3_inverse_macros.svh =====
// assertion macros for the 3x3 inverse block
// used by the port checker, expects clk and rst_n in scope
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH

// property that holds every cycle outside reset
`define M3I_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a check in the next
`define M3I_ASSERT_NEXT(lbl, cond, chk, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) else $error(msg);

`endif

// ===== rtl/core/m3i_pkg.sv =====
// widths, cofactor tables and saturation constants for the 3x3 inverse
// no dependencies
package m3i_pkg;

    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int CELLS    = 9;
    localparam int PW       = 2 * WORD_W;          // element product
    localparam int CW       = 2 * WORD_W + 1;      // cofactor
    localparam int DPW      = 2 * WORD_W + 1;      // partial det product
    localparam int DTW      = CW + WORD_W;         // element times cofactor
    localparam int DETW     = DTW + 2;             // determinant
    localparam int NMW      = 2 * WORD_W;          // cofactor magnitude
    localparam int NW       = NMW + 2 * FRAC_W;    // dividend
    localparam int DMW      = DETW;                // divisor magnitude
    localparam int QB       = WORD_W + 1;          // quotient bits kept
    localparam int QRW      = QB + 1;              // rounded quotient
    localparam int CMPW     = ((NW > DMW) ? NW : DMW) + 1;
    localparam int SUBW     = DMW + QB;
    localparam int DIV_ST   = QB + 2;              // load, one per bit, round
    localparam int FRONT_ST = 6;
    localparam int NSTAGE   = FRONT_ST + DIV_ST + 1;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [3:0] idx_t;

    // cofactor c = m[a]*m[b] - m[c]*m[d], checkerboard sign folded in
    localparam idx_t COF_A [CELLS] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
    localparam idx_t COF_B [CELLS] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
    localparam idx_t COF_C [CELLS] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
    localparam idx_t COF_D [CELLS] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

    // output element to cofactor (transpose)
    localparam idx_t TRANS [CELLS] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t ONE_RAW  = (FRAC_W >= WORD_W - 1) ? WORD_MAX
                                 : word_t'(64'(1) << FRAC_W);

    localparam logic [QRW-1:0] Q_HALF = QRW'(1) << (WORD_W - 1);
    localparam logic [QRW-1:0] Q_PMAX = Q_HALF - QRW'(1);

endpackage

// ===== rtl/core/m3i_div.sv =====
// pipelined restoring divider, one quotient bit per stage, rounded at the end
// depends on m3i_pkg
module m3i_div
    import m3i_pkg::*;
(
    input  logic              clk,
    input  logic [DIV_ST-1:0] adv,
    input  logic [NMW-1:0]    nmag,
    input  logic [DMW-1:0]    dmag,
    input  logic              neg,
    output logic [QRW-1:0]    qr,
    output logic              ovf,
    output logic              neg_o
);

    logic [NW-1:0]  r_reg   [QB+1];
    logic [DMW-1:0] d_reg   [QB+1];
    logic [QB-1:0]  q_reg   [QB+1];
    logic           ovf_reg [QB+1];
    logic           neg_reg [QB+1];
    logic [QB:1]    take;
    logic [NW-1:0]  n_next;
    logic           ovf_next;
    logic           rb;
    logic [QRW-1:0] qr_reg;
    logic           ovf_out_reg;
    logic           neg_out_reg;

    assign n_next   = NW'(nmag) << (2 * FRAC_W);
    // quotient would need more than QB bits: saturates anyway
    assign ovf_next = CMPW'(n_next >> QB) >= CMPW'(dmag);

    always_comb
    begin
        for (int s = 1; s <= QB; s++)
        begin
            take[s] = CMPW'(r_reg[s-1] >> (QB - s)) >= CMPW'(d_reg[s-1]);
        end
    end

    assign rb = CMPW'({r_reg[QB], 1'b0}) >= CMPW'(d_reg[QB]);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            r_reg[0]   <= n_next;
            d_reg[0]   <= dmag;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
            neg_reg[0] <= neg;
        end
        for (int s = 1; s <= QB; s++)
        begin
            if (adv[s])
            begin
                r_reg[s]   <= take[s]
                              ? r_reg[s-1] - NW'(SUBW'(d_reg[s-1]) << (QB - s))
                              : r_reg[s-1];
                q_reg[s]   <= q_reg[s-1] | (QB'(take[s]) << (QB - s));
                d_reg[s]   <= d_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
        // round to nearest, ties away from zero on the magnitude
        if (adv[DIV_ST-1])
        begin
            qr_reg      <= QRW'(q_reg[QB]) + QRW'(rb);
            ovf_out_reg <= ovf_reg[QB];
            neg_out_reg <= neg_reg[QB];
        end
    end

    assign qr    = qr_reg;
    assign ovf   = ovf_out_reg;
    assign neg_o = neg_out_reg;

endmodule

// ===== rtl/core/matrix3x3_inverse.sv =====
// 3x3 fixed point matrix inverse: adjugate over determinant, fully pipelined.
// Takes one matrix per clock and returns one inverse per clock while out_ready is high.
// It has six stages of products, cofactors and determinant, then a 35-stage restoring
// divider per element (one quotient bit per stage), then saturation into the
// output register. Stalls from out_ready fill bubbles first; in_ready drops only
// when every stage holds a beat. Depends on m3i_pkg and m3i_div.
module matrix3x3_inverse
    import m3i_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] in_r0c0,
    input  logic [WORD_W-1:0] in_r0c1,
    input  logic [WORD_W-1:0] in_r0c2,
    input  logic [WORD_W-1:0] in_r1c0,
    input  logic [WORD_W-1:0] in_r1c1,
    input  logic [WORD_W-1:0] in_r1c2,
    input  logic [WORD_W-1:0] in_r2c0,
    input  logic [WORD_W-1:0] in_r2c1,
    input  logic [WORD_W-1:0] in_r2c2,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_r0c0,
    output logic [WORD_W-1:0] out_r0c1,
    output logic [WORD_W-1:0] out_r0c2,
    output logic [WORD_W-1:0] out_r1c0,
    output logic [WORD_W-1:0] out_r1c1,
    output logic [WORD_W-1:0] out_r1c2,
    output logic [WORD_W-1:0] out_r2c0,
    output logic [WORD_W-1:0] out_r2c1,
    output logic [WORD_W-1:0] out_r2c2,
    output logic              singular
);

    word_t                  m_in [CELLS];
    logic [NSTAGE-1:0]      v_reg;
    logic [NSTAGE-1:0]      v_next;
    logic [NSTAGE-1:0]      adv;

    logic signed [PW-1:0]   prod0_reg [2*CELLS];
    word_t                  top0_reg  [3];
    logic signed [CW-1:0]   cof1_reg  [CELLS];
    word_t                  top1_reg  [3];
    logic signed [DPW-1:0]  plo2_reg  [3];
    logic signed [DPW-1:0]  phi2_reg  [3];
    logic signed [CW-1:0]   cof2_reg  [CELLS];
    logic signed [DTW-1:0]  prod3_reg [3];
    logic signed [CW-1:0]   cof3_reg  [CELLS];
    logic signed [DETW-1:0] det4_reg;
    logic signed [CW-1:0]   cof4_reg  [CELLS];
    logic [NMW-1:0]         nmag5_reg [CELLS];
    logic                   neg5_reg  [CELLS];
    logic [DMW-1:0]         dmag5_reg;
    logic                   zero5_reg;
    logic [DIV_ST-1:0]      sing_reg;

    logic [QRW-1:0]         qr   [CELLS];
    logic                   ovf  [CELLS];
    logic                   qneg [CELLS];
    word_t                  res_next [CELLS];
    word_t                  res_reg  [CELLS];
    logic                   sing_out_reg;

    assign m_in[0] = in_r0c0;
    assign m_in[1] = in_r0c1;
    assign m_in[2] = in_r0c2;
    assign m_in[3] = in_r1c0;
    assign m_in[4] = in_r1c1;
    assign m_in[5] = in_r1c2;
    assign m_in[6] = in_r2c0;
    assign m_in[7] = in_r2c1;
    assign m_in[8] = in_r2c2;

    // a stage may load when out_ready is high or when it or any stage after it is empty
    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_adv
        assign adv[i] = out_ready || !(&v_reg[NSTAGE-1:i]);
    end

    assign in_ready = adv[0];

    always_comb
    begin
        v_next = v_reg;
        if (adv[0])
        begin
            v_next[0] = in_valid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (adv[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int c = 0; c < CELLS; c++)
            begin
                prod0_reg[2*c]   <= m_in[COF_A[c]] * m_in[COF_B[c]];
                prod0_reg[2*c+1] <= m_in[COF_C[c]] * m_in[COF_D[c]];
            end
            for (int k = 0; k < 3; k++)
            begin
                top0_reg[k] <= m_in[k];
            end
        end
        if (adv[1])
        begin
            for (int c = 0; c < CELLS; c++)
            begin
                cof1_reg[c] <= CW'(prod0_reg[2*c]) - CW'(prod0_reg[2*c+1]);
            end
            top1_reg <= top0_reg;
        end
        // determinant terms split so each multiply is word by word plus one
        if (adv[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                plo2_reg[k] <= DPW'(top1_reg[k])
                               * DPW'($signed({1'b0, cof1_reg[k][WORD_W-1:0]}));
                phi2_reg[k] <= DPW'(top1_reg[k])
                               * DPW'($signed(cof1_reg[k][CW-1:WORD_W]));
            end
            cof2_reg <= cof1_reg;
        end
        if (adv[3])
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod3_reg[k] <= (DTW'(phi2_reg[k]) <<< WORD_W) + DTW'(plo2_reg[k]);
            end
            cof3_reg <= cof2_reg;
        end
        if (adv[4])
        begin
            det4_reg <= DETW'(prod3_reg[0]) + DETW'(prod3_reg[1]) + DETW'(prod3_reg[2]);
            cof4_reg <= cof3_reg;
        end
        if (adv[5])
        begin
            dmag5_reg <= det4_reg[DETW-1] ? DMW'(-det4_reg) : DMW'(det4_reg);
            zero5_reg <= (det4_reg == '0);
            for (int o = 0; o < CELLS; o++)
            begin
                nmag5_reg[o] <= cof4_reg[TRANS[o]][CW-1] ? NMW'(-cof4_reg[TRANS[o]])
                                                          : NMW'(cof4_reg[TRANS[o]]);
                neg5_reg[o]  <= cof4_reg[TRANS[o]][CW-1] ^ det4_reg[DETW-1];
            end
        end
        // singular flag rides alongside the divider stages
        if (adv[FRONT_ST])
        begin
            sing_reg[0] <= zero5_reg;
        end
        for (int s = 1; s < DIV_ST; s++)
        begin
            if (adv[FRONT_ST+s])
            begin
                sing_reg[s] <= sing_reg[s-1];
            end
        end
        if (adv[NSTAGE-1])
        begin
            res_reg      <= res_next;
            sing_out_reg <= sing_reg[DIV_ST-1];
        end
    end

    for (genvar o = 0; o < CELLS; o++)
    begin : g_div
        m3i_div u_div (
            .clk   (clk),
            .adv   (adv[FRONT_ST +: DIV_ST]),
            .nmag  (nmag5_reg[o]),
            .dmag  (dmag5_reg),
            .neg   (neg5_reg[o]),
            .qr    (qr[o]),
            .ovf   (ovf[o]),
            .neg_o (qneg[o])
        );
    end

    always_comb
    begin
        for (int o = 0; o < CELLS; o++)
        begin
            if (sing_reg[DIV_ST-1])
            begin
                res_next[o] = (o % 4 == 0) ? ONE_RAW : '0;
            end
            else if (qneg[o])
            begin
                res_next[o] = (ovf[o] || qr[o] > Q_HALF) ? WORD_MIN
                                                         : word_t'(WORD_W'(-qr[o]));
            end
            else
            begin
                res_next[o] = (ovf[o] || qr[o] > Q_PMAX) ? WORD_MAX
                                                         : word_t'(WORD_W'(qr[o]));
            end
        end
    end

    assign out_valid = v_reg[NSTAGE-1];
    assign singular  = sing_out_reg;
    assign out_r0c0  = res_reg[0];
    assign out_r0c1  = res_reg[1];
    assign out_r0c2  = res_reg[2];
    assign out_r1c0  = res_reg[3];
    assign out_r1c1  = res_reg[4];
    assign out_r1c2  = res_reg[5];
    assign out_r2c0  = res_reg[6];
    assign out_r2c1  = res_reg[7];
    assign out_r2c2  = res_reg[8];

endmodule

// ===== rtl/core/m3i_checker.sv =====
// port-level checks for matrix3x3_inverse, attached by bind
// depends on m3i_pkg and matrix3x3_inverse_macros.svh
`include "matrix3x3_inverse_macros.svh"

module m3i_checker
    import m3i_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [WORD_W-1:0] out_r0c0,
    input logic [WORD_W-1:0] out_r0c1,
    input logic [WORD_W-1:0] out_r0c2,
    input logic [WORD_W-1:0] out_r1c0,
    input logic [WORD_W-1:0] out_r1c1,
    input logic [WORD_W-1:0] out_r1c2,
    input logic [WORD_W-1:0] out_r2c0,
    input logic [WORD_W-1:0] out_r2c1,
    input logic [WORD_W-1:0] out_r2c2,
    input logic              singular
);

    // a stalled result beat stays put
    `M3I_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
    `M3I_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(out_r0c0) && $stable(out_r1c1) && $stable(out_r2c2) && $stable(singular),
        "result beat changed while stalled")

    // a draining output never blocks the input
    `M3I_ASSERT(a_flow, !out_ready || in_ready, "input blocked while output drains")

    // singular results are the identity
    `M3I_ASSERT(a_ident, !(out_valid && singular) ||
        (out_r0c1 == '0 && out_r0c2 == '0 && out_r1c0 == '0 && out_r1c2 == '0 &&
         out_r2c0 == '0 && out_r2c1 == '0 && out_r0c0 == out_r1c1 &&
         out_r1c1 == out_r2c2 && out_r0c0 != '0), "singular result is not identity")

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (.*);
